// ===== rtl/core/hkee_pkg.sv =====
// Package for the HID keyboard event extractor.
// Types, event layout and modifier constants shared by hkee_diff, hkee_serializer and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hkee_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int MOD_EVENTS = 6;
  localparam int N_EVENTS = MOD_EVENTS + 2 * KEY_SLOTS;

  localparam logic [7:0] CODE_CTRL = 8'hE0;
  localparam logic [7:0] CODE_SHIFT = 8'hE1;
  localparam logic [7:0] CODE_ALT = 8'hE2;

  // Modifier groups in emit order: shift, ctrl, alt
  localparam logic [2:0][7:0] GROUP_MASK = {8'h44, 8'h11, 8'h22};

  // Event slots 0..5: release/press per group
  localparam logic [MOD_EVENTS-1:0][7:0] MOD_CODE = {
    CODE_ALT, CODE_ALT, CODE_CTRL, CODE_CTRL, CODE_SHIFT, CODE_SHIFT
  };

  typedef logic [7:0] keycode_t;
  typedef logic [KEY_SLOTS-1:0][7:0] key_arr_t;
  typedef logic [N_EVENTS-1:0] event_mask_t;

  // Event layout: modifiers, then key releases, then key presses
  localparam event_mask_t PRESS_SEL = {{KEY_SLOTS{1'b1}}, {KEY_SLOTS{1'b0}}, 6'b101010};

  typedef struct packed {
    event_mask_t mask;
    key_arr_t    prior_keys;
    key_arr_t    new_keys;
  } hkee_batch_t;

endpackage

`default_nettype wire

// ===== rtl/core/hkee_if.sv =====
// Channel interfaces of the HID keyboard event extractor: report in, event out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hkee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  modport source (
    output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
           key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
           key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

interface hkee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_key;
  logic       is_press;
  logic       last_event;

  modport source (
    output valid, event_key, is_press, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_key, is_press, last_event,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/hkee_diff.sv =====
// Report compare: builds the event mask of a new report against the prior one.
// Depends on hkee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hkee_diff (
  input  wire logic [7:0]         mods,
  input  wire hkee_pkg::key_arr_t keys,
  input  wire logic [7:0]         prior_mods,
  input  wire hkee_pkg::key_arr_t prior_keys,
  output hkee_pkg::hkee_batch_t   batch
);
  import hkee_pkg::*;

  logic [7:0]           released;
  logic [7:0]           pressed;
  logic [KEY_SLOTS-1:0] rel_key;
  logic [KEY_SLOTS-1:0] prs_key;
  logic [KEY_SLOTS-1:0] in_new;
  logic [KEY_SLOTS-1:0] in_prior;

  assign released = prior_mods & ~mods;
  assign pressed  = mods & ~prior_mods;

  always_comb begin
    for (int s = 0; s < KEY_SLOTS; s++) begin
      in_new[s]   = 1'b0;
      in_prior[s] = 1'b0;
      for (int t = 0; t < KEY_SLOTS; t++) begin
        if (keys[t] == prior_keys[s]) in_new[s] = 1'b1;
        if (prior_keys[t] == keys[s]) in_prior[s] = 1'b1;
      end
      rel_key[s] = (prior_keys[s] != 8'h00) && !in_new[s];
      prs_key[s] = (keys[s] != 8'h00) && !in_prior[s];
    end
  end

  always_comb begin
    batch.mask = '0;
    for (int g = 0; g < 3; g++) begin
      batch.mask[2*g]   = |(released & GROUP_MASK[g]);
      batch.mask[2*g+1] = |(pressed & GROUP_MASK[g]);
    end
    batch.mask[MOD_EVENTS +: KEY_SLOTS]             = rel_key;
    batch.mask[MOD_EVENTS + KEY_SLOTS +: KEY_SLOTS] = prs_key;
    batch.prior_keys = prior_keys;
    batch.new_keys   = keys;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hkee_serializer.sv =====
// Event serializer: holds one report's event mask and emits the lowest pending
// event into the output register per cycle it is free. Depends on hkee_pkg, hkee_if.
`timescale 1ns / 1ps
`default_nettype none

module hkee_serializer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load_valid,
  output logic                       load_ready,
  input  wire hkee_pkg::hkee_batch_t load_batch,
  hkee_out_if.source                 out_evt
);
  import hkee_pkg::*;

  event_mask_t                 mask_r, mask_nxt;
  key_arr_t                    prior_r, new_r;
  logic                        out_valid_r, out_valid_nxt;
  keycode_t                    key_r;
  logic                        press_r;
  logic                        last_r;

  logic                        pending;
  logic                        out_free;
  logic                        advance;
  event_mask_t                 onehot;
  event_mask_t                 rest;
  logic [N_EVENTS-1:0][7:0]    codes;
  keycode_t                    sel_code;

  assign pending  = |mask_r;
  assign out_free = !out_valid_r || out_evt.ready;
  assign advance  = pending && out_free;
  assign onehot   = mask_r & (~mask_r + 1'b1);
  assign rest     = mask_r & ~onehot;
  assign load_ready = !pending || (advance && (rest == '0));

  always_comb begin
    for (int i = 0; i < MOD_EVENTS; i++) codes[i] = MOD_CODE[i];
    for (int s = 0; s < KEY_SLOTS; s++) begin
      codes[MOD_EVENTS + s]             = prior_r[s];
      codes[MOD_EVENTS + KEY_SLOTS + s] = new_r[s];
    end
    sel_code = '0;
    for (int i = 0; i < N_EVENTS; i++) begin
      sel_code = sel_code | ({8{onehot[i]}} & codes[i]);
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load_valid && load_ready) begin
      mask_nxt = load_batch.mask;
    end else if (advance) begin
      mask_nxt = rest;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      prior_r <= load_batch.prior_keys;
      new_r   <= load_batch.new_keys;
    end
    if (advance) begin
      key_r   <= sel_code;
      press_r <= |(onehot & PRESS_SEL);
      last_r  <= (rest == '0);
    end
  end

  assign out_evt.valid      = out_valid_r;
  assign out_evt.event_key  = key_r;
  assign out_evt.is_press   = press_r;
  assign out_evt.last_event = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/hid_keyboard_event_extractor_unit.sv =====
// HID boot keyboard report to key event converter, top level.
// Depends on hkee_pkg, hkee_if, hkee_diff, hkee_serializer.
//
// Each accepted boot keyboard report is compared against the previous report
// (all zero after reset) and turned into up to 18 key events: merged shift
// (E1), ctrl (E0) and alt (E2) release/press, then releases of dropped keys
// in slot order, then presses of new keys in slot order; last_event marks a
// report's final event. Events leave at one per cycle from a registered
// output while the sink is ready. A report holds the serializer until
// its last event moves to the output register; the next report is taken
// in that cycle. A report with no events produces no output.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_event_extractor_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hkee_in_if.sink    in_rpt,
  hkee_out_if.source out_evt
);
  import hkee_pkg::*;

  logic [7:0]  prior_mods_r, prior_mods_nxt;
  key_arr_t    prior_keys_r, prior_keys_nxt;
  key_arr_t    keys;
  hkee_batch_t batch;
  logic        load_ready;
  logic        accept;

  assign keys = {in_rpt.key_slot_5, in_rpt.key_slot_4, in_rpt.key_slot_3,
                 in_rpt.key_slot_2, in_rpt.key_slot_1, in_rpt.key_slot_0};

  assign in_rpt.ready = load_ready;
  assign accept = in_rpt.valid && load_ready;

  hkee_diff u_diff (
    .mods       (in_rpt.modifier_bits),
    .keys       (keys),
    .prior_mods (prior_mods_r),
    .prior_keys (prior_keys_r),
    .batch      (batch)
  );

  hkee_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_rpt.valid),
    .load_ready (load_ready),
    .load_batch (batch),
    .out_evt    (out_evt)
  );

  always_comb begin
    prior_mods_nxt = prior_mods_r;
    prior_keys_nxt = prior_keys_r;
    if (accept) begin
      prior_mods_nxt = in_rpt.modifier_bits;
      prior_keys_nxt = keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_mods_r <= '0;
      prior_keys_r <= '0;
    end else begin
      prior_mods_r <= prior_mods_nxt;
      prior_keys_r <= prior_keys_nxt;
    end
  end

endmodule

`default_nettype wire
